[sv/rbc_pkg.sv]
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types for the counting rank block: cell control and the link that
// runs between neighboring cells.
// ----------------------------------------------------------------------------
package rbc_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 6;

    // One phase at a time; all zero means every cell holds.
    typedef struct packed {
        logic load;   // shift a new value in at cell 0
        logic rank;   // compare against the circulating value, rotate the ring
        logic emit;   // shift finished ranks toward the far end
    } t_ctrl;

    typedef struct packed {
        logic               vld;    // cell holds a stored value
        logic [VALUE_W-1:0] key;    // stored value, sign bit flipped
        logic               tvld;   // circulating value is valid
        logic [VALUE_W-1:0] trv;    // circulating value, sign bit flipped
        logic [RANK_W-1:0]  rank;   // count of smaller values seen so far
    } t_link;

endpackage

[sv/rbc_cell.sv]
// ----------------------------------------------------------------------------
// rbc_cell
// One cell of the ranking chain: holds one stored value, a circulating copy
// that travels around the ring, and a running count of smaller values.
// ----------------------------------------------------------------------------
module rbc_cell
    import rbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctrl i_ctrl,
    input  t_link i_link,
    output t_link o_link
);

    logic               r_vld;
    logic               r_tvld;
    logic [VALUE_W-1:0] r_key;
    logic [VALUE_W-1:0] r_trv;
    logic [RANK_W-1:0]  r_rank;

    logic               w_smaller;

    assign w_smaller = r_tvld && (r_trv < r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_tvld <= 1'b0;
        end else if (i_ctrl.load) begin
            r_vld  <= i_link.vld;
            r_tvld <= i_link.vld;
        end else if (i_ctrl.rank) begin
            r_tvld <= i_link.tvld;
        end else if (i_ctrl.emit) begin
            r_vld  <= i_link.vld;
            // drop the travelers so the next set starts clean
            r_tvld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_key  <= i_link.key;
            r_trv  <= i_link.key;
            r_rank <= '0;
        end else if (i_ctrl.rank) begin
            r_trv <= i_link.trv;
            if (w_smaller) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end else if (i_ctrl.emit) begin
            r_rank <= i_link.rank;
        end
    end

    assign o_link.vld  = r_vld;
    assign o_link.key  = r_key;
    assign o_link.tvld = r_tvld;
    assign o_link.trv  = r_trv;
    assign o_link.rank = r_rank;

endmodule

[sv/rank_by_counting.sv]
// ----------------------------------------------------------------------------
// rank_by_counting
// Ranks a set of signed values by counting, for each, the stored values
// strictly below it, using a row of compare cells.
// ----------------------------------------------------------------------------
// Values load one per cycle while busy is low; a beat with i_last closes the
// set. Values past MAX_ITEMS are dropped and flag o_overflow on every result
// of the set. After the closing beat busy stays high through two phases: a
// rank phase in which the stored values rotate once around the cell ring,
// each cell comparing its stored value against each of them in turn, then an
// emit phase in which the ranks shift out of the chain end, one o_valid beat per
// stored value in load order, the last marked by o_last_res. The receiver
// cannot stall: every o_valid beat is taken in the cycle it appears.
// ----------------------------------------------------------------------------
module rank_by_counting
    import rbc_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_valid,
    output logic [RANK_W-1:0]        o_rank,
    output logic                     o_overflow,
    output logic                     o_last_res
);

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int STEP_W = $clog2(MAX_ITEMS);

    typedef enum logic [1:0] {
        S_LOAD,
        S_RANK,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [STEP_W-1:0]   r_step;
    logic                r_ovf;

    logic                w_accept;
    logic                w_full;
    t_ctrl               w_ctrl;
    t_link               w_links [0:MAX_ITEMS];

    assign busy     = (r_state != S_LOAD);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(MAX_ITEMS));

    assign w_ctrl.load = w_accept && !w_full;
    assign w_ctrl.rank = (r_state == S_RANK);
    assign w_ctrl.emit = (r_state == S_EMIT);

    // Cell 0 takes new values; the traveler ring closes from the far end.
    assign w_links[0].vld  = w_ctrl.load;
    assign w_links[0].key  = {~i_value[VALUE_W-1], i_value[VALUE_W-2:0]};
    assign w_links[0].tvld = w_links[MAX_ITEMS].tvld;
    assign w_links[0].trv  = w_links[MAX_ITEMS].trv;
    assign w_links[0].rank = '0;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        rbc_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (w_ctrl),
            .i_link (w_links[g]),
            .o_link (w_links[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_count    <= '0;
            r_step     <= '0;
            r_ovf      <= 1'b0;
            o_valid    <= 1'b0;
            o_rank     <= '0;
            o_overflow <= 1'b0;
            o_last_res <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_last) begin
                            r_step  <= '0;
                            r_state <= S_RANK;
                        end
                    end
                end
                S_RANK: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(MAX_ITEMS - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_links[MAX_ITEMS].vld) begin
                        o_valid    <= 1'b1;
                        o_rank     <= w_links[MAX_ITEMS].rank;
                        o_overflow <= r_ovf;
                        o_last_res <= (r_count == CNT_W'(1));
                        r_count    <= r_count - CNT_W'(1);
                        if (r_count == CNT_W'(1)) begin
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("stored count beyond store depth");

    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EMIT))
        else $error("result beat outside emission phase");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_res |-> !busy && r_count == '0 && !r_ovf)
        else $error("set not closed after final result");

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_res |-> r_state == S_EMIT && r_count != '0)
        else $error("emission ended before final result");

endmodule
